/* sv/urx_pkg.sv */
// Shared types, codes and constants for the edge-timestamp UART receiver.
`timescale 1ns / 1ps

package urx_pkg;

    localparam logic [2:0] FUNC_EDGE    = 3'd0;
    localparam logic [2:0] FUNC_TIMEOUT = 3'd1;
    localparam logic [2:0] FUNC_READ    = 3'd2;
    localparam logic [2:0] FUNC_PEEK    = 3'd3;
    localparam logic [2:0] FUNC_FLUSH   = 3'd4;

    localparam logic [1:0] CFG_BIT_PERIOD   = 2'd0;
    localparam logic [1:0] CFG_FIRST_OFFSET = 2'd1;
    localparam logic [1:0] CFG_STOP_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_RX_ENABLE    = 2'd3;

    localparam logic [15:0] RST_BIT_PERIOD   = 16'd694;
    localparam logic [15:0] RST_FIRST_OFFSET = 16'd741;
    localparam logic [15:0] RST_STOP_TIMEOUT = 16'd6419;

    // eight sample points per frame: count 8 means the next shift ends it
    localparam logic [3:0] LAST_SAMPLE = 4'd8;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] capture_time;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  data;
        logic        data_valid;
        logic [5:0]  fill_level;
        logic        byte_stored;
        logic        byte_dropped;
        logic        timeout_armed;
        logic [15:0] timeout_deadline;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EDGE,
        S_TMO,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic edge_first;
        logic edge_step;
        logic tmo_step;
        logic finish;
        logic rd_issue;
        logic flush;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       count_zero;
        logic       edge_due;
        logic       last_bit;
        logic       armed;
        logic       can_read;
        logic       out_free;
    } t_dp_stat;

endpackage

/* sv/urx_in_if.sv */
// Input word channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps

interface urx_in_if
    import urx_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/urx_out_if.sv */
// Output word channel: valid/ready handshake carrying one result word.
`timescale 1ns / 1ps

interface urx_out_if
    import urx_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/urx_ctrl.sv */
// Sequencing state machine for the receiver datapath.
`timescale 1ns / 1ps

module urx_ctrl
    import urx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FUNC_EDGE:    n_state = i_stat.count_zero ? S_DONE : S_EDGE;
                    FUNC_TIMEOUT: n_state = i_stat.armed ? S_TMO : S_DONE;
                    default:      n_state = S_DONE;
                endcase
            end
            S_EDGE: begin
                if (!i_stat.edge_due) n_state = S_DONE;
                else if (i_stat.last_bit) n_state = S_FIN;
            end
            S_TMO: begin
                if (i_stat.last_bit) n_state = S_FIN;
            end
            S_FIN: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    FUNC_EDGE:  o_cmd.edge_first = 1'b1;
                    FUNC_READ,
                    FUNC_PEEK:  o_cmd.rd_issue = i_stat.can_read;
                    FUNC_FLUSH: o_cmd.flush = 1'b1;
                    default:    o_cmd = '0;
                endcase
            end
            S_EDGE:  o_cmd.edge_step = i_stat.edge_due;
            S_TMO:   o_cmd.tmo_step = 1'b1;
            S_FIN:   o_cmd.finish = 1'b1;
            S_DONE:  o_cmd.res_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/urx_dp.sv */
// Receiver datapath: config, frame shifter, timers, receive ring, result register.
`timescale 1ns / 1ps

module urx_dp
    import urx_pkg::*;
#(
    parameter int RING_CAPACITY = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  t_in_word    i_in_word,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output t_out_word   o_out_word,
    output logic        o_out_valid,
    input  logic        i_out_ready
);

    localparam int DEPTH  = RING_CAPACITY + 1;
    localparam int SW     = $clog2(DEPTH);
    localparam int FILL_W = (SW + 1 > 6) ? SW + 1 : 6;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        next_slot = (s >= SW'(RING_CAPACITY)) ? '0 : s + 1'b1;
    endfunction

    logic [15:0]   r_bit_period, r_first_off, r_stop_to;
    logic          r_rx_en;
    logic [2:0]    r_func, n_func;
    logic [15:0]   r_time, n_time;
    logic          r_level, n_level;
    logic [3:0]    r_count, n_count;
    logic [7:0]    r_shift, n_shift;
    logic [15:0]   r_target, n_target;
    logic          r_armed, n_armed;
    logic [15:0]   r_deadline, n_deadline;
    logic [SW-1:0] r_wr_slot, n_wr_slot;
    logic [SW-1:0] r_rd_slot, n_rd_slot;
    logic          r_rd_valid, n_rd_valid;
    logic          r_stored, n_stored;
    logic          r_dropped, n_dropped;
    t_out_word     r_out_word, n_out_word;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_mem_q;

    logic [15:0]     time_diff;
    logic [SW-1:0]   wr_next, rd_next;
    logic            ring_full;
    logic [FILL_W-1:0] fill;

    assign time_diff = r_time - r_target;
    assign wr_next   = next_slot(r_wr_slot);
    assign rd_next   = next_slot(r_rd_slot);
    assign ring_full = (wr_next == r_rd_slot);

    always_comb begin
        fill = FILL_W'(r_wr_slot) - FILL_W'(r_rd_slot);
        if (r_wr_slot < r_rd_slot) fill = fill + FILL_W'(DEPTH);
        if (!r_rx_en) fill = '0;
    end

    assign o_stat.func       = r_func;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.edge_due   = ~time_diff[15];
    assign o_stat.last_bit   = (r_count == LAST_SAMPLE);
    assign o_stat.armed      = r_armed;
    assign o_stat.can_read   = r_rx_en && (r_rd_slot != r_wr_slot);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_word  = r_out_word;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= RST_BIT_PERIOD;
            r_first_off  <= RST_FIRST_OFFSET;
            r_stop_to    <= RST_STOP_TIMEOUT;
            r_rx_en      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BIT_PERIOD:   r_bit_period <= i_cfg_data;
                CFG_FIRST_OFFSET: r_first_off  <= i_cfg_data;
                CFG_STOP_TIMEOUT: r_stop_to    <= i_cfg_data;
                CFG_RX_ENABLE:    r_rx_en      <= i_cfg_data[0];
                default:          r_rx_en      <= r_rx_en;
            endcase
        end
    end

    always_comb begin
        n_func      = r_func;
        n_time      = r_time;
        n_level     = r_level;
        n_count     = r_count;
        n_shift     = r_shift;
        n_target    = r_target;
        n_armed     = r_armed;
        n_deadline  = r_deadline;
        n_wr_slot   = r_wr_slot;
        n_rd_slot   = r_rd_slot;
        n_rd_valid  = r_rd_valid;
        n_stored    = r_stored;
        n_dropped   = r_dropped;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid;

        if (i_cmd.capture) begin
            n_func     = i_in_word.func;
            n_time     = i_in_word.capture_time;
            n_rd_valid = 1'b0;
            n_stored   = 1'b0;
            n_dropped  = 1'b0;
        end
        if (i_cmd.edge_first) begin
            n_level = ~r_level;
            if (r_count == '0 && !r_level) begin
                n_deadline = r_time + r_stop_to;
                n_armed    = 1'b1;
                n_target   = r_time + r_first_off;
                n_count    = 4'd1;
            end
        end
        if (i_cmd.edge_step) begin
            n_shift  = {r_level, r_shift[7:1]};
            n_target = r_target + r_bit_period;
            n_count  = r_count + 4'd1;
        end
        if (i_cmd.tmo_step) begin
            n_shift = {~r_level, r_shift[7:1]};
            n_count = r_count + 4'd1;
        end
        if (i_cmd.finish) begin
            n_armed = 1'b0;
            n_level = 1'b0;
            n_count = '0;
            if (!ring_full) begin
                n_wr_slot = wr_next;
                n_stored  = 1'b1;
            end else begin
                n_dropped = 1'b1;
            end
        end
        if (i_cmd.rd_issue) begin
            n_rd_valid = 1'b1;
            if (r_func == FUNC_READ) n_rd_slot = rd_next;
        end
        if (i_cmd.flush) begin
            n_rd_slot = '0;
            n_wr_slot = '0;
        end
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (i_cmd.res_load) begin
            n_out_valid                 = 1'b1;
            n_out_word.data             = r_rd_valid ? r_mem_q : 8'd0;
            n_out_word.data_valid       = r_rd_valid;
            n_out_word.fill_level       = fill[5:0];
            n_out_word.byte_stored      = r_stored;
            n_out_word.byte_dropped     = r_dropped;
            n_out_word.timeout_armed    = r_armed;
            n_out_word.timeout_deadline = r_armed ? r_deadline : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= 1'b0;
            r_count     <= '0;
            r_armed     <= 1'b0;
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_out_valid <= 1'b0;
            r_shift     <= '0;
            r_target    <= '0;
            r_deadline  <= '0;
        end else begin
            r_level     <= n_level;
            r_count     <= n_count;
            r_armed     <= n_armed;
            r_wr_slot   <= n_wr_slot;
            r_rd_slot   <= n_rd_slot;
            r_out_valid <= n_out_valid;
            r_shift     <= n_shift;
            r_target    <= n_target;
            r_deadline  <= n_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_time     <= n_time;
        r_rd_valid <= n_rd_valid;
        r_stored   <= n_stored;
        r_dropped  <= n_dropped;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !ring_full) r_mem[wr_next] <= r_shift;
        if (i_cmd.rd_issue) r_mem_q <= r_mem[rd_next];
    end

endmodule

/* sv/uart_rx_edge_timestamp_decoder_core.sv */
// Top level of the edge-timestamp 8N1 UART receiver with receive ring.
`timescale 1ns / 1ps

// Takes one command word at a time (edge, timeout, read, peek, flush) and
// returns exactly one status word for each. Read, peek, flush, an ignored
// timeout and an edge that starts a frame go straight from dispatch to the
// result register. An edge inside a frame walks the sample points one per
// cycle, and when that completes the byte the ring write takes the place of
// the final compare. A timeout shifts in the missing bits before the ring
// write. The next word is accepted while a result still waits in the output
// register. The ring holds RING_CAPACITY bytes in a RING_CAPACITY+1 entry
// memory with a registered read port and needs no clearing after reset.
module uart_rx_edge_timestamp_decoder_core
    import urx_pkg::*;
#(
    parameter int RING_CAPACITY = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    urx_in_if.sink      i_in,
    urx_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    urx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    urx_dp #(
        .RING_CAPACITY (RING_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in.payload),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_word  (o_out.payload),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready)
    );

    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("word accepted while previous word still in work");

    a_finish_only_when_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |-> dp_stat.armed)
        else $error("frame completion without a pending deadline");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> dp_stat.out_free)
        else $error("result overwrites a word not yet taken");

    a_store_drop_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.payload.byte_stored && o_out.payload.byte_dropped))
        else $error("byte both stored and dropped");

endmodule
